// ===== hw/rtl/chfx_pkg.sv =====
// Shared types and constants for the compass heading block.
`default_nettype none

package chfx_pkg;

	// Register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_X_OFFSET    = 2'd0,
		REG_Y_OFFSET    = 2'd1,
		REG_DECLINATION = 2'd2
	} cfg_reg_t;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int RAW_W = 16;
	localparam int DECL_W = 15;
	localparam int HEAD_W = 9;
	localparam int IN_TDATA_W = 32;
	localparam int OUT_TDATA_W = 16;

	// Offset-corrected samples, the CORDIC datapath and its angle accumulator
	localparam int CORR_W = RAW_W + 1;
	localparam int PRESCALE_SH = 8;
	localparam int CW = 28;
	localparam int ZW = 20;
	localparam int ANG_W = ZW - 4;
	localparam int HRAW_W = ANG_W + 1;
	localparam int HWRAP_W = 15;

	localparam logic signed [ZW-1:0] HALF_PI_Z = 20'sd102944;
	localparam logic signed [ANG_W-1:0] PI_Q = 16'sd12868;
	localparam logic signed [HRAW_W+0:0] TWO_PI_X = 18'sd25736;
	localparam logic signed [HRAW_W+0:0] FOUR_PI_X = 18'sd51472;

	localparam logic signed [HEAD_W-1:0] HEAD_MIN = -9'sd179;
	localparam logic signed [HEAD_W-1:0] HEAD_MAX = 9'sd180;
	localparam logic [HEAD_W-1:0] DEG_HALF = 9'd180;
	localparam logic [HEAD_W-1:0] DEG_FULL = 9'd360;

	// Degrees = floor(h * 180 / PI) by multiplying with a rounded-up reciprocal;
	// exact for every product below 2^23, so for every wrapped heading.
	localparam int DEG_SHIFT = 37;
	localparam longint unsigned DEG_RECIP =
		((64'd1 << DEG_SHIFT) + 64'd12867) / 64'd12868;
	localparam logic [31:0] DEG_MULT = 32'(DEG_RECIP * 64'd180);
	localparam int PROD_W = HWRAP_W + 32;

	// round(atan(2^-i) * 2^16)
	function automatic logic signed [ZW-1:0] atan_q16(input int unsigned i);
		logic signed [ZW-1:0] r;
		case (i)
			0:       r = 20'sd51472;
			1:       r = 20'sd30385;
			2:       r = 20'sd16055;
			3:       r = 20'sd8150;
			4:       r = 20'sd4091;
			5:       r = 20'sd2047;
			6:       r = 20'sd1024;
			7:       r = 20'sd512;
			8:       r = 20'sd256;
			9:       r = 20'sd128;
			10:      r = 20'sd64;
			11:      r = 20'sd32;
			12:      r = 20'sd16;
			13:      r = 20'sd8;
			14:      r = 20'sd4;
			15:      r = 20'sd2;
			16:      r = 20'sd1;
			17:      r = 20'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/compass_heading_from_xy.sv =====
// Compass heading from one magnetometer X/Y sample, as a pipelined CORDIC.
//
// An item on the s_ stream carries x_raw and y_raw; the block subtracts the
// hard-iron offsets, finds atan2(y, x) with one CORDIC iteration per stage,
// subtracts the declination, wraps into 0..2pi and emits the heading in whole
// degrees (-179..180) as one item on the m_ stream.
// Throughput is one item per clock while the receiver does not stall. An
// accepted item passes through the offset stage, prerotation, CORDIC_STAGES
// iterations, rounding and declination, wrap and degree multiply, and then
// the output register, where it shows on m_tvalid.
// The three registers are written through the cfg_ port, which is always
// ready; they must only change while no item is in flight.
// Reset empties the pipeline and loads the calibration defaults.
// When the receiver stalls, the next result to reach the end of the pipeline
// lands in a skid register and the whole pipeline then holds; s_tready falls
// in the cycle after that and rises again right after the receiver takes the
// waiting item.
`default_nettype none

module compass_heading_from_xy
	import chfx_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire  [CFG_IDX_W-1:0]       cfg_index,
	input  wire  [CFG_DATA_W-1:0]      cfg_data,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire  [IN_TDATA_W-1:0]      s_tdata,   // [15:0] x_raw, [31:16] y_raw
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [OUT_TDATA_W-1:0]     m_tdata    // [8:0] heading_deg, rest zero
);

	localparam int N = CORDIC_STAGES;

	logic signed [RAW_W-1:0]  x_offset_q;
	logic signed [RAW_W-1:0]  y_offset_q;
	logic signed [DECL_W-1:0] decl_q;

	logic en;
	logic push;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q <= -16'sd953;
			y_offset_q <= 16'sd817;
			decl_q     <= 15'sd283;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_X_OFFSET:    x_offset_q <= cfg_data;
				REG_Y_OFFSET:    y_offset_q <= cfg_data;
				REG_DECLINATION: decl_q <= cfg_data[DECL_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: offset correction
	logic                     v_s1;
	logic signed [CORR_W-1:0] x_s1;
	logic signed [CORR_W-1:0] y_s1;

	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= CORR_W'($signed(s_tdata[15:0])) - CORR_W'(x_offset_q);
			y_s1 <= CORR_W'($signed(s_tdata[31:16])) - CORR_W'(y_offset_q);
		end
	end

	// Stage 2: prerotation into the right half plane, then one iteration a stage
	logic [N:0]               v_s2;
	logic                     zero_s2 [N+1];
	logic signed [CW-1:0]     cx_s2 [N+1];
	logic signed [CW-1:0]     cy_s2 [N+1];
	logic signed [ZW-1:0]     cz_s2 [N+1];

	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;

	always_comb begin
		xs = {{(CW-CORR_W-PRESCALE_SH){x_s1[CORR_W-1]}}, x_s1, {PRESCALE_SH{1'b0}}};
		ys = {{(CW-CORR_W-PRESCALE_SH){y_s1[CORR_W-1]}}, y_s1, {PRESCALE_SH{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2[0] <= 1'b0;
		end else if (en) begin
			v_s2[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2[0] <= (x_s1 == '0) && (y_s1 == '0);
			if (!x_s1[CORR_W-1]) begin
				cx_s2[0] <= xs;
				cy_s2[0] <= ys;
				cz_s2[0] <= '0;
			end else if (!y_s1[CORR_W-1]) begin
				cx_s2[0] <= ys;
				cy_s2[0] <= -xs;
				cz_s2[0] <= HALF_PI_Z;
			end else begin
				cx_s2[0] <= -ys;
				cy_s2[0] <= xs;
				cz_s2[0] <= -HALF_PI_Z;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [ZW-1:0] da;

		assign dx = cy_s2[i] >>> i;
		assign dy = cx_s2[i] >>> i;
		assign da = atan_q16(i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[i+1] <= 1'b0;
			end else if (en) begin
				v_s2[i+1] <= v_s2[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s2[i+1] <= zero_s2[i];
				if (!cy_s2[i][CW-1]) begin
					cx_s2[i+1] <= cx_s2[i] + dx;
					cy_s2[i+1] <= cy_s2[i] - dy;
					cz_s2[i+1] <= cz_s2[i] + da;
				end else begin
					cx_s2[i+1] <= cx_s2[i] - dx;
					cy_s2[i+1] <= cy_s2[i] + dy;
					cz_s2[i+1] <= cz_s2[i] - da;
				end
			end
		end
	end

	// Stage 3: round to 2^-12 rad, clamp to +-pi, subtract declination
	logic                     v_s3;
	logic signed [HRAW_W-1:0] h_s3;
	logic signed [ZW-1:0]     zr;
	logic signed [ANG_W-1:0]  ang;

	always_comb begin
		zr = cz_s2[N] + ZW'(8);
		ang = zr[ZW-1:4];
		if (zero_s2[N]) begin
			ang = '0;
		end else if (ang > PI_Q) begin
			ang = PI_Q;
		end else if (ang < -PI_Q) begin
			ang = -PI_Q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s3 <= HRAW_W'(ang) - HRAW_W'(decl_q);
		end
	end

	// Stage 4: wrap into 0..2pi; exactly 2pi is kept
	logic                      v_s4;
	logic [HWRAP_W-1:0]        h_s4;
	logic signed [HRAW_W:0]    hx;
	logic signed [HRAW_W:0]    hw;

	always_comb begin
		hx = (HRAW_W+1)'(h_s3);
		if (hx < -TWO_PI_X) begin
			hw = hx + FOUR_PI_X;
		end else if (hx < 0) begin
			hw = hx + TWO_PI_X;
		end else if (hx > TWO_PI_X) begin
			hw = hx - TWO_PI_X;
		end else begin
			hw = hx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s4 <= hw[HWRAP_W-1:0];
		end
	end

	// Stage 5: degrees by reciprocal multiplication
	logic              v_s5;
	logic [PROD_W-1:0] prod_s5;
	logic [HEAD_W-1:0] deg;
	logic [HEAD_W-1:0] head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= PROD_W'(h_s4) * PROD_W'(DEG_MULT);
		end
	end

	always_comb begin
		deg = prod_s5[DEG_SHIFT+HEAD_W-1:DEG_SHIFT];
		head = (deg > DEG_HALF) ? deg - DEG_FULL : deg;
	end

	// Output register with a skid register behind it
	logic              out_vld_q;
	logic              skid_vld_q;
	logic [HEAD_W-1:0] out_q;
	logic [HEAD_W-1:0] skid_q;

	assign en = !skid_vld_q;
	assign push = en && v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_vld_q && !m_tready) begin
			if (push) begin
				skid_vld_q <= 1'b1;
			end
		end else if (skid_vld_q) begin
			out_vld_q  <= 1'b1;
			skid_vld_q <= 1'b0;
		end else begin
			out_vld_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (out_vld_q && !m_tready) begin
			if (push) begin
				skid_q <= head;
			end
		end else if (skid_vld_q) begin
			out_q <= skid_q;
		end else if (push) begin
			out_q <= head;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {{(OUT_TDATA_W-HEAD_W){1'b0}}, out_q};

endmodule

`default_nettype wire

// ===== hw/rtl/chfx_checker.sv =====
// Port-level checks for the compass heading block, bound to its top level.
`default_nettype none

module chfx_checker
	import chfx_pkg::*;
(
	input wire                    clk,
	input wire                    arst_n,
	input wire                    s_tready,
	input wire                    m_tvalid,
	input wire                    m_tready,
	input wire [OUT_TDATA_W-1:0]  m_tdata
);

	logic signed [HEAD_W-1:0] hd;

	assign hd = m_tdata[HEAD_W-1:0];

	// A result held back by the receiver stays unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or vanished");

	// Headings stay within -179..180 and the padding bits stay clear.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (hd >= HEAD_MIN) && (hd <= HEAD_MAX) &&
			(m_tdata[OUT_TDATA_W-1:HEAD_W] == '0))
		else $error("heading out of range");

	// The input side only blocks after the output was stalled.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("input blocked without an output stall");

	// The input side is unblocked in the cycle after the receiver is ready again.
	a_ready_back: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready && m_tready |=> s_tready)
		else $error("input stays blocked after the output drained");

endmodule

bind compass_heading_from_xy chfx_checker u_chfx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
